// ===== rtl/npt_pkg.sv =====
`timescale 1ns / 1ps

package npt_pkg;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	localparam int STATUS_BITS = 2;
	localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} npt_state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic scan_step;
		logic load_out;
	} npt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic scan_last;
		logic pipe_busy;
	} npt_stat_t;

endpackage

// ===== rtl/npt_ctrl.sv =====
`timescale 1ns / 1ps

module npt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_cmd,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  npt_pkg::npt_stat_t  stat,
	output npt_pkg::npt_cmd_t   cmd
);
	import npt_pkg::*;

	npt_state_t state_q;
	npt_state_t state_next;
	logic       out_valid_q;

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		cmd.accept    = (state_q == ST_IDLE) && in_valid;
		cmd.scan_step = (state_q == ST_SCAN);
		cmd.load_out  = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_cmd == CMD_QUERY && !stat.empty)
						state_next = ST_SCAN;
					else
						state_next = ST_EMIT;
				end
			end
			ST_SCAN: begin
				if (stat.scan_last)
					state_next = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy)
					state_next = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready)
					state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/npt_datapath.sv =====
`timescale 1ns / 1ps

module npt_datapath #(
	parameter int TABLE_DEPTH = 256,
	parameter int COORD_BITS  = 10,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int DW = 2 * COORD_BITS + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  npt_pkg::npt_cmd_t             cmd,
	output npt_pkg::npt_stat_t            stat,
	input  logic                          in_cmd,
	input  logic [COORD_BITS-1:0]         in_x,
	input  logic [COORD_BITS-1:0]         in_y,
	output logic [npt_pkg::STATUS_BITS-1:0] out_status,
	output logic [AW-1:0]                 out_index,
	output logic [DW-1:0]                 out_dist
);
	import npt_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int PW = 2 * COORD_BITS;

	// point table, entry = {y, x}
	logic [PW-1:0] mem [TABLE_DEPTH];

	logic [CW-1:0]         count_q;
	logic [COORD_BITS-1:0] qx_q;
	logic [COORD_BITS-1:0] qy_q;
	logic [AW-1:0]         addr_q;
	logic                  full;
	logic                  empty;
	logic                  do_write;

	logic [PW-1:0]         rd_s1;
	logic [AW-1:0]         idx_s1;
	logic                  v_s1;
	logic [COORD_BITS-1:0] dx_s2;
	logic [COORD_BITS-1:0] dy_s2;
	logic [AW-1:0]         idx_s2;
	logic                  v_s2;
	logic [PW-1:0]         sqx_s3;
	logic [PW-1:0]         sqy_s3;
	logic [AW-1:0]         idx_s3;
	logic                  v_s3;
	logic [DW-1:0]         d_s4;
	logic [AW-1:0]         idx_s4;
	logic                  v_s4;

	logic                  best_valid_q;
	logic                  take_best;
	logic [STATUS_BITS-1:0] res_status_q;
	logic [AW-1:0]         res_index_q;
	logic [DW-1:0]         res_dist_q;
	logic [STATUS_BITS-1:0] out_status_q;
	logic [AW-1:0]         out_index_q;
	logic [DW-1:0]         out_dist_q;

	logic [COORD_BITS-1:0] rx;
	logic [COORD_BITS-1:0] ry;

	assign full     = (count_q == CW'(TABLE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_write = cmd.accept && (in_cmd == CMD_INSERT) && !full;

	assign stat.empty     = empty;
	assign stat.scan_last = ({{(CW-AW){1'b0}}, addr_q} == (count_q - CW'(1)));
	assign stat.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_write) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_write)
			mem[count_q[AW-1:0]] <= {in_y, in_x};
		if (cmd.scan_step)
			rd_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			qx_q   <= in_x;
			qy_q   <= in_y;
			addr_q <= '0;
		end else if (cmd.scan_step) begin
			addr_q <= addr_q + AW'(1);
		end
	end

	assign rx = rd_s1[COORD_BITS-1:0];
	assign ry = rd_s1[PW-1:COORD_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_step;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		dx_s2  <= (qx_q >= rx) ? (qx_q - rx) : (rx - qx_q);
		dy_s2  <= (qy_q >= ry) ? (qy_q - ry) : (ry - qy_q);
		idx_s2 <= idx_s1;
		sqx_s3 <= PW'(dx_s2) * PW'(dx_s2);
		sqy_s3 <= PW'(dy_s2) * PW'(dy_s2);
		idx_s3 <= idx_s2;
		d_s4   <= DW'(sqx_s3) + DW'(sqy_s3);
		idx_s4 <= idx_s3;
	end

	// strict less-than keeps the lower index on a tie
	assign take_best = v_s4 && (!best_valid_q || (d_s4 < res_dist_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
		end else if (cmd.accept) begin
			best_valid_q <= 1'b0;
		end else if (take_best) begin
			best_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_dist_q <= '0;
			if (in_cmd == CMD_INSERT) begin
				res_status_q <= full ? STATUS_FULL : STATUS_OK;
				res_index_q  <= full ? '0 : count_q[AW-1:0];
			end else begin
				res_status_q <= empty ? STATUS_EMPTY : STATUS_OK;
				res_index_q  <= '0;
			end
		end else if (take_best) begin
			res_index_q <= idx_s4;
			res_dist_q  <= d_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_dist_q   <= res_dist_q;
		end
	end

	assign out_status = out_status_q;
	assign out_index  = out_index_q;
	assign out_dist   = out_dist_q;

endmodule

// ===== rtl/nearest_point_table_unit.sv =====
`timescale 1ns / 1ps

// Nearest point table: stores up to TABLE_DEPTH 2-D points and answers
// nearest-neighbor queries by linear scan.
// Input beat (s_axis): tuser = cmd (0 insert, 1 query), tdata = point.
// Output beat (m_axis): tuser = status (0 ok, 1 full, 2 empty),
//   tdata = nearest/written index and squared distance (0 for inserts).
// One input beat gives exactly one output beat, in order.
// Timing: an insert, a query on an empty table, or an insert into a full
//   table goes from acceptance through the emit state to the output beat. A
//   query on N stored points scans the table memory, which gives one entry per
//   cycle, followed by a drain of the distance/compare pipeline.
// One item is in flight at a time; s_axis_tready is high only while idle.
// The output register holds one finished beat, so the next input beat can
//   be accepted while m_axis stalls; that item then waits before its result
//   is loaded until the held beat is taken.
// Reset empties the table at once (entry count cleared, no sweep) and drops
//   any pending output beat.
module nearest_point_table_unit #(
	parameter int TABLE_DEPTH = 256,
	parameter int COORD_BITS  = 10
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	// pos_x, pos_y, zero pad
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
	// cmd
	input  logic                                     s_axis_tuser,

	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	// index, dist_sq, zero pad
	output logic [(($clog2(TABLE_DEPTH)+2*COORD_BITS+1+7)/8)*8-1:0] m_axis_tdata,
	// status
	output logic [npt_pkg::STATUS_BITS-1:0]          m_axis_tuser
);
	import npt_pkg::*;

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int DW  = 2 * COORD_BITS + 1;
	localparam int OTW = ((AW + DW + 7) / 8) * 8;

	npt_cmd_t  cmd;
	npt_stat_t stat;

	logic [AW-1:0] out_index;
	logic [DW-1:0] out_dist;

	npt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_cmd    (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	npt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.COORD_BITS  (COORD_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_cmd     (s_axis_tuser),
		.in_x       (s_axis_tdata[COORD_BITS-1:0]),
		.in_y       (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
		.out_status (m_axis_tuser),
		.out_index  (out_index),
		.out_dist   (out_dist)
	);

	assign m_axis_tdata = OTW'({out_dist, out_index});

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import npt_pkg::*;

	localparam int TABLE_DEPTH = 256;
	localparam int COORD_BITS  = 10;
	localparam int IDX_BITS    = 8;
	localparam int DIST_BITS   = 21;
	localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
	localparam int RANDOM_PER_PHASE = 445;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 20;
	localparam int EXP_DEPTH   = 4096;
	localparam int EXP_AW      = 12;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [IDX_BITS-1:0]    index;
		logic [DIST_BITS-1:0]   dist_sq;
	} table_result_t;

	typedef struct packed {
		logic                   cmd;
		logic [COORD_BITS-1:0]  x;
		logic [COORD_BITS-1:0]  y;
		logic                   exact;
		logic [STATUS_BITS-1:0] status;
		logic [IDX_BITS-1:0]    index;
		logic [DIST_BITS-1:0]   dist_sq;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [STATUS_BITS-1:0] m_axis_tuser;

	nearest_point_table_unit #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.COORD_BITS(COORD_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// shadow copy of the point table
	logic [COORD_BITS-1:0] shadow_x [TABLE_DEPTH];
	logic [COORD_BITS-1:0] shadow_y [TABLE_DEPTH];
	int stored_count;

	// expected beats in order of acceptance
	table_result_t expect_fifo [EXP_DEPTH];
	int exp_wr;
	int exp_rd;
	table_result_t want_r;

	int idle_pct;
	int stall_pct;
	int hold_req;
	int hold_left;
	int error_count;
	int results_seen;
	int cycle_count;
	int n_insert, n_full, n_query, n_empty;

	dir_row_t dir_rows [19] = '{
		'{CMD_QUERY,  10'd0,    10'd0,    1'b1, STATUS_EMPTY, 8'd0, 21'd0},
		'{CMD_QUERY,  10'd1023, 10'd1023, 1'b1, STATUS_EMPTY, 8'd0, 21'd0},
		'{CMD_INSERT, 10'd0,    10'd0,    1'b1, STATUS_OK,    8'd0, 21'd0},
		'{CMD_QUERY,  10'd1023, 10'd1023, 1'b1, STATUS_OK,    8'd0, 21'd2093058},
		'{CMD_INSERT, 10'd1023, 10'd1023, 1'b1, STATUS_OK,    8'd1, 21'd0},
		// equal distance to both stored corners: lower entry wins
		'{CMD_QUERY,  10'd1023, 10'd0,    1'b1, STATUS_OK,    8'd0, 21'd1046529},
		'{CMD_QUERY,  10'd0,    10'd1023, 1'b1, STATUS_OK,    8'd0, 21'd1046529},
		'{CMD_INSERT, 10'd1023, 10'd0,    1'b1, STATUS_OK,    8'd2, 21'd0},
		'{CMD_INSERT, 10'd0,    10'd1023, 1'b1, STATUS_OK,    8'd3, 21'd0},
		'{CMD_QUERY,  10'd512,  10'd512,  1'b0, STATUS_OK,    8'd0, 21'd0},
		'{CMD_INSERT, 10'd0,    10'd0,    1'b1, STATUS_OK,    8'd4, 21'd0},
		'{CMD_QUERY,  10'd0,    10'd0,    1'b1, STATUS_OK,    8'd0, 21'd0},
		'{CMD_INSERT, 10'd341,  10'd682,  1'b1, STATUS_OK,    8'd5, 21'd0},
		'{CMD_INSERT, 10'd682,  10'd341,  1'b1, STATUS_OK,    8'd6, 21'd0},
		'{CMD_QUERY,  10'd683,  10'd341,  1'b0, STATUS_OK,    8'd0, 21'd0},
		'{CMD_QUERY,  10'd340,  10'd683,  1'b0, STATUS_OK,    8'd0, 21'd0},
		'{CMD_QUERY,  10'd1023, 10'd1023, 1'b1, STATUS_OK,    8'd1, 21'd0},
		'{CMD_INSERT, 10'd1,    10'd1,    1'b1, STATUS_OK,    8'd7, 21'd0},
		'{CMD_QUERY,  10'd2,    10'd0,    1'b0, STATUS_OK,    8'd0, 21'd0}
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// insert or nearest-point search on the shadow table
	function automatic table_result_t nearest_or_insert(logic cmd, logic [COORD_BITS-1:0] x,
			logic [COORD_BITS-1:0] y);
		table_result_t r;
		int dx, dy, d, best_d, best_i;
		r = '0;
		r.status = STATUS_OK;
		if (cmd == CMD_INSERT) begin
			if (stored_count >= TABLE_DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				shadow_x[stored_count] = x;
				shadow_y[stored_count] = y;
				r.index = stored_count[IDX_BITS-1:0];
				stored_count++;
			end
		end else if (stored_count == 0) begin
			r.status = STATUS_EMPTY;
		end else begin
			best_d = -1;
			best_i = 0;
			for (int i = 0; i < stored_count; i++) begin
				dx = int'(x) - int'(shadow_x[i]);
				dy = int'(y) - int'(shadow_y[i]);
				d = dx * dx + dy * dy;
				if (best_d < 0 || d < best_d) begin
					best_d = d;
					best_i = i;
				end
			end
			r.index = best_i[IDX_BITS-1:0];
			r.dist_sq = best_d[DIST_BITS-1:0];
		end
		return r;
	endfunction

	function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
		if (v < 0)
			return '0;
		if (v > COORD_MAX)
			return COORD_MAX[COORD_BITS-1:0];
		return v[COORD_BITS-1:0];
	endfunction

	// mix of uniform points, points near or on stored ones, and corners
	task automatic pick_point(output logic [COORD_BITS-1:0] x, output logic [COORD_BITS-1:0] y);
		int kind, k;
		kind = $urandom_range(9);
		k = (stored_count > 0) ? $urandom_range(stored_count - 1) : 0;
		if (stored_count == 0 || kind < 4) begin
			x = COORD_BITS'($urandom_range(COORD_MAX));
			y = COORD_BITS'($urandom_range(COORD_MAX));
		end else if (kind < 7) begin
			x = clamp_coord(int'(shadow_x[k]) + $urandom_range(6) - 3);
			y = clamp_coord(int'(shadow_y[k]) + $urandom_range(6) - 3);
		end else if (kind < 9) begin
			x = shadow_x[k];
			y = shadow_y[k];
		end else begin
			x = $urandom_range(1) ? COORD_MAX[COORD_BITS-1:0] : '0;
			y = $urandom_range(1) ? COORD_MAX[COORD_BITS-1:0] : '0;
		end
	endtask

	task automatic send_beat(logic cmd, logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
			logic exact, table_result_t typed);
		table_result_t r;
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser = cmd;
		s_axis_tdata = {4'b0, y, x};
		do
			@(posedge clk);
		while (!s_axis_tready);
		r = nearest_or_insert(cmd, x, y);
		case (r.status)
			STATUS_FULL: n_full++;
			STATUS_EMPTY: n_empty++;
			default: ;
		endcase
		if (cmd == CMD_INSERT)
			n_insert++;
		else
			n_query++;
		expect_fifo[exp_wr[EXP_AW-1:0]] = exact ? typed : r;
		exp_wr++;
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH beat %0d %s: got %0d, expected %0d", results_seen, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (exp_wr == exp_rd) begin
				report_mismatch("beat with nothing outstanding", m_axis_tdata, 0);
			end else begin
				want_r = expect_fifo[exp_rd[EXP_AW-1:0]];
				exp_rd++;
				if (m_axis_tuser !== want_r.status)
					report_mismatch("status", m_axis_tuser, want_r.status);
				if (m_axis_tdata[7:0] !== want_r.index)
					report_mismatch("index", m_axis_tdata[7:0], want_r.index);
				if (m_axis_tdata[28:8] !== want_r.dist_sq)
					report_mismatch("dist_sq", m_axis_tdata[28:8], want_r.dist_sq);
				if (m_axis_tdata[31:29] !== 3'b0)
					report_mismatch("tdata pad", m_axis_tdata[31:29], 0);
			end
			results_seen++;
		end
	end

	// receiver: random stalls plus an optional long hold-off
	initial begin
		m_axis_tready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else begin
				m_axis_tready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("watchdog expired at %0d cycles, %0d beats outstanding", cycle_count,
			exp_wr - exp_rd);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic cmd;
		logic [COORD_BITS-1:0] x, y;
		int pct;
		table_result_t typed;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		error_count = 0;
		results_seen = 0;
		stored_count = 0;
		exp_wr = 0;
		exp_rd = 0;
		n_insert = 0;
		n_full = 0;
		n_query = 0;
		n_empty = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			typed.status = dir_rows[i].status;
			typed.index = dir_rows[i].index;
			typed.dist_sq = dir_rows[i].dist_sq;
			send_beat(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y, dir_rows[i].exact, typed);
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 56; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 56; end
				default: begin idle_pct = 11; stall_pct = 11; end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// long output hold-off while inputs keep coming: block backs up
				if ((ph == 0 && n == 120) || (ph == 3 && n == 200))
					hold_req = 400;
				// fill slowly so queries see every table depth, then keep
				// probing the full-table reject
				pct = (stored_count < TABLE_DEPTH) ? 35 : 15;
				cmd = ($urandom_range(99) < pct) ? CMD_INSERT : CMD_QUERY;
				pick_point(x, y);
				send_beat(cmd, x, y, 1'b0, '0);
			end
		end
		@(negedge clk);
		s_axis_tvalid = 1'b0;

		while (exp_wr != exp_rd)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d inserts (%0d rejected as full) and %0d queries (%0d on empty table)",
			n_insert, n_full, n_query, n_empty);
		$display("%0d result beats checked over %0d cycles, table depth reached %0d",
			results_seen, cycle_count, stored_count);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
